// ----- rtl/heat_budget_fire_limiter_core_macros.svh -----
// assertion macros shared by the heat budget fire limiter rtl
`ifndef HEAT_BUDGET_FIRE_LIMITER_CORE_MACROS_SVH
`define HEAT_BUDGET_FIRE_LIMITER_CORE_MACROS_SVH

// consequence holds in the same cycle as the antecedent
`define HBFL_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the antecedent
`define HBFL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hbfl_pkg.sv -----
// shared types, constants and helpers of the heat budget fire limiter
`default_nettype none

package hbfl_pkg;

    localparam int HEAT_W       = 16;
    localparam int COOL_W       = 12;
    localparam int SPEED_W      = 16;
    localparam int SHOT_W       = 16;
    localparam int TIME_W       = 32;
    localparam int ALLOW_W      = 16;
    localparam int MARGIN_OUT_W = 25;
    localparam int DIFF_W       = HEAT_W + 1;
    localparam int PROD_W       = COOL_W + TIME_W;
    localparam int PSAT_W       = 30;
    localparam int QUOT_W       = 24;
    localparam int REM_W        = 7;
    localparam int REM_DEPTH    = 1 << REM_W;
    localparam int QUOT_DIVISOR = 125;
    localparam int FIRED_MUL_W  = SHOT_W + 4;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 48;

    // floor(x / 125) = (x * RECIP_125) >> RECIP_SHIFT for x below 2^30
    localparam logic [PSAT_W-1:0] RECIP_125   = 30'd549755814;
    localparam int                RECIP_SHIFT = 36;

    // floor(x / 10) = (x * DIV10_RECIP) >> DIV10_SHIFT for 16 bit x
    localparam logic [15:0] DIV10_RECIP = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAT_LIMIT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLING_RATE = 1'b1;

    localparam logic [HEAT_W-1:0] HEAT_LIMIT_RESET   = 16'd240;
    localparam logic [COOL_W-1:0] COOLING_RATE_RESET = 12'd40;

    typedef logic signed [ALLOW_W-1:0] shots_t;

    localparam shots_t SHOTS_MIN = 16'sh8000;

    typedef struct packed {
        logic                link;
        logic [HEAT_W-1:0]   heat;
        logic [SPEED_W-1:0]  speed;
        logic [SHOT_W-1:0]   shots;
        logic [TIME_W-1:0]   time_ms;
        logic                left_alive;
        logic                right_alive;
    } item_t;

    typedef struct packed {
        logic                     link;
        logic                     wheels_ok;
        logic                     speed_chg;
        logic                     heat_chg;
        logic signed [DIFF_W-1:0] diff;
        logic [SHOT_W-1:0]        fired;
        logic [PSAT_W-1:0]        p_sat;
    } front_t;

    typedef struct packed {
        logic   link;
        logic   wheels_ok;
        logic   speed_chg;
        logic   heat_chg;
        shots_t diff_q;
    } flags_t;

    function automatic logic [15:0] div10_u16(input logic [15:0] x);
        logic [31:0] prod;
        prod = 32'(x) * 32'(DIV10_RECIP);
        return 16'(prod >> DIV10_SHIFT);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/hbfl_front.sv -----
// input register, change detection, elapsed time and cooling product
`default_nettype none
`include "heat_budget_fire_limiter_core_macros.svh"

module hbfl_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hbfl_pkg::item_t               in_item,
    input  logic [hbfl_pkg::HEAT_W-1:0]   heat_limit,
    input  logic [hbfl_pkg::COOL_W-1:0]   cooling_rate,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hbfl_pkg::front_t              out_front
);
    import hbfl_pkg::*;

    logic                 a_valid_reg;
    item_t                a_item_reg;
    logic                 b_valid_reg;
    front_t               b_front_reg;
    logic                 a_ready;
    logic                 b_ready;
    logic                 a_adv;

    logic [HEAT_W-1:0]    last_heat_reg;
    logic [SPEED_W-1:0]   last_speed_reg;
    logic [SHOT_W-1:0]    last_shot_reg;
    logic [TIME_W-1:0]    last_time_reg;

    logic [TIME_W-1:0]    dt;
    logic [PROD_W-1:0]    prod;
    front_t               b_front_next;

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign a_adv    = a_valid_reg && b_ready;
    assign in_ready = a_ready;

    assign out_valid = b_valid_reg;
    assign out_front = b_front_reg;

    // elapsed time wraps modulo 2^32
    assign dt   = a_item_reg.time_ms - last_time_reg;
    assign prod = PROD_W'(cooling_rate) * PROD_W'(dt);

    always_comb begin
        b_front_next.link      = a_item_reg.link;
        b_front_next.wheels_ok = a_item_reg.left_alive && a_item_reg.right_alive;
        b_front_next.speed_chg = a_item_reg.speed != last_speed_reg;
        b_front_next.heat_chg  = (a_item_reg.heat != last_heat_reg) || (a_item_reg.heat == '0);
        b_front_next.diff      = $signed({1'b0, heat_limit}) - $signed({1'b0, a_item_reg.heat});
        b_front_next.fired     = a_item_reg.shots - last_shot_reg;
        // past 2^30 the recovery always overshoots the cap
        b_front_next.p_sat     = (|prod[PROD_W-1:PSAT_W]) ? '1 : prod[PSAT_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            last_heat_reg  <= '0;
            last_speed_reg <= '0;
            last_shot_reg  <= '0;
            last_time_reg  <= '0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (a_adv) begin
                if (a_item_reg.link) begin
                    last_heat_reg  <= a_item_reg.heat;
                    last_speed_reg <= a_item_reg.speed;
                end else begin
                    last_shot_reg  <= a_item_reg.shots;
                    last_time_reg  <= a_item_reg.time_ms;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && a_ready) begin
            a_item_reg <= in_item;
        end
        if (a_adv) begin
            b_front_reg <= b_front_next;
        end
    end

    `HBFL_ASSERT_NEXT(a_est_time_follows, aclk, aresetn,
        a_adv && !a_item_reg.link, last_time_reg == $past(a_item_reg.time_ms),
        "estimate time not taken from the local estimate transaction")

endmodule

`default_nettype wire

// ----- rtl/hbfl_margin.sv -----
// recovery quotient, reload count and the q-format heat margin
`default_nettype none
`include "heat_budget_fire_limiter_core_macros.svh"

module hbfl_margin #(
    parameter int HEAT_FRAC_BITS = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  hbfl_pkg::front_t                       in_front,
    input  logic [hbfl_pkg::HEAT_W-1:0]            heat_limit,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output hbfl_pkg::flags_t                       out_flags,
    output logic signed [HEAT_FRAC_BITS+17:0]      out_margin
);
    import hbfl_pkg::*;

    localparam int MW = HEAT_FRAC_BITS + 18;
    localparam int SW = HEAT_FRAC_BITS + 23;
    localparam int GW = HEAT_FRAC_BITS + 21;
    localparam int TW = HEAT_FRAC_BITS - 3;

    // fraction part of floor(r * 2^(F-3) / 125) for each remainder r
    function automatic logic [REM_DEPTH*TW-1:0] build_frac_tab();
        logic [REM_DEPTH*TW-1:0] tab;
        tab = '0;
        for (int i = 0; i < REM_DEPTH; i++) begin
            tab[i*TW +: TW] = TW'((longint'(i) << (HEAT_FRAC_BITS - 3)) / QUOT_DIVISOR);
        end
        return tab;
    endfunction

    localparam logic [REM_DEPTH*TW-1:0] FRAC_TAB = build_frac_tab();

    logic                     c_valid_reg;
    front_t                   c_front_reg;
    logic [QUOT_W-1:0]        c_q_reg;
    shots_t                   c_diff_q_reg;
    logic                     d_valid_reg;
    flags_t                   d_flags_reg;
    logic signed [MW-1:0]     margin_reg;

    logic                     c_ready;
    logic                     d_ready;
    logic                     c_adv;

    logic [2*PSAT_W-1:0]      q_prod;
    logic [QUOT_W-1:0]        q_next;
    logic [DIFF_W-1:0]        diff_mag;
    logic [15:0]              diff_q10;
    shots_t                   diff_q_next;

    logic [REM_W-1:0]         rem;
    logic [TW-1:0]            frac;
    logic [GW-1:0]            gain;
    logic [FIRED_MUL_W-1:0]   fired10;
    logic signed [SW-1:0]     m_ext;
    logic signed [SW-1:0]     fired_sh;
    logic signed [SW-1:0]     gain_s;
    logic signed [SW-1:0]     cap_s;
    logic signed [SW-1:0]     sum;
    logic signed [SW-1:0]     clamped;
    logic signed [MW-1:0]     margin_next;
    flags_t                   d_flags_next;

    assign d_ready  = !d_valid_reg || out_ready;
    assign c_ready  = !c_valid_reg || d_ready;
    assign c_adv    = c_valid_reg && d_ready;
    assign in_ready = c_ready;

    assign out_valid  = d_valid_reg;
    assign out_flags  = d_flags_reg;
    assign out_margin = margin_reg;

    // quotient of the cooling product by 125
    assign q_prod = (2*PSAT_W)'(in_front.p_sat) * (2*PSAT_W)'(RECIP_125);
    assign q_next = q_prod[RECIP_SHIFT +: QUOT_W];

    // reload count, truncated toward zero
    assign diff_mag    = in_front.diff[DIFF_W-1] ? DIFF_W'(-in_front.diff)
                                                 : DIFF_W'(in_front.diff);
    assign diff_q10    = div10_u16(diff_mag[15:0]);
    assign diff_q_next = in_front.diff[DIFF_W-1] ? -$signed(diff_q10) : $signed(diff_q10);

    // remainder only needs its low bits since it stays below 128
    assign rem  = REM_W'(c_front_reg.p_sat[REM_W-1:0]
                  - REM_W'(c_q_reg[REM_W-1:0] * REM_W'(QUOT_DIVISOR)));
    assign frac = FRAC_TAB[rem*TW +: TW];
    assign gain = (GW'(c_q_reg) << (HEAT_FRAC_BITS - 3)) | GW'(frac);

    assign fired10  = (FIRED_MUL_W'(c_front_reg.fired) << 3)
                    + (FIRED_MUL_W'(c_front_reg.fired) << 1);
    assign m_ext    = SW'(margin_reg);
    assign fired_sh = $signed({{(SW-FIRED_MUL_W-HEAT_FRAC_BITS){1'b0}}, fired10,
                               {HEAT_FRAC_BITS{1'b0}}});
    assign gain_s   = $signed({{(SW-GW){1'b0}}, gain});
    assign cap_s    = $signed({{(SW-HEAT_W-HEAT_FRAC_BITS){1'b0}}, heat_limit,
                               {HEAT_FRAC_BITS{1'b0}}});
    assign sum      = m_ext - fired_sh + gain_s;

    always_comb begin
        if (sum > cap_s) begin
            clamped = cap_s;
        end else if (sum[SW-1]) begin
            clamped = '0;
        end else begin
            clamped = sum;
        end
        if (c_front_reg.link) begin
            margin_next = MW'($signed({c_front_reg.diff, {HEAT_FRAC_BITS{1'b0}}}));
        end else begin
            margin_next = MW'(clamped);
        end
        d_flags_next.link      = c_front_reg.link;
        d_flags_next.wheels_ok = c_front_reg.wheels_ok;
        d_flags_next.speed_chg = c_front_reg.speed_chg;
        d_flags_next.heat_chg  = c_front_reg.heat_chg;
        d_flags_next.diff_q    = c_diff_q_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            margin_reg  <= '0;
        end else begin
            if (c_ready) begin
                c_valid_reg <= in_valid;
            end
            if (d_ready) begin
                d_valid_reg <= c_valid_reg;
            end
            if (c_adv) begin
                margin_reg <= margin_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && c_ready) begin
            c_front_reg  <= in_front;
            c_q_reg      <= q_next;
            c_diff_q_reg <= diff_q_next;
        end
        if (c_adv) begin
            d_flags_reg <= d_flags_next;
        end
    end

    `HBFL_ASSERT_NEXT(a_estimate_nonneg, aclk, aresetn,
        c_adv && !c_front_reg.link, !margin_reg[MW-1],
        "local estimate left a negative heat margin")

endmodule

`default_nettype wire

// ----- rtl/hbfl_shots.sv -----
// allowed shot count, fire decision and the result register
`default_nettype none
`include "heat_budget_fire_limiter_core_macros.svh"

module hbfl_shots #(
    parameter int HEAT_FRAC_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  hbfl_pkg::flags_t                   in_flags,
    input  logic signed [HEAT_FRAC_BITS+17:0]  in_margin,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               out_fire,
    output hbfl_pkg::shots_t                   out_allowed,
    output logic signed [HEAT_FRAC_BITS+17:0]  out_margin
);
    import hbfl_pkg::*;

    localparam int MW = HEAT_FRAC_BITS + 18;

    logic                  o_valid_reg;
    logic                  o_fire_reg;
    shots_t                o_allowed_reg;
    logic signed [MW-1:0]  o_margin_reg;
    shots_t                shots_reg;
    shots_t                shots_next;
    logic                  fire_next;
    logic                  in_adv;

    assign in_ready    = !o_valid_reg || out_ready;
    assign in_adv      = in_valid && in_ready;
    assign out_valid   = o_valid_reg;
    assign out_fire    = o_fire_reg;
    assign out_allowed = o_allowed_reg;
    assign out_margin  = o_margin_reg;

    always_comb begin
        shots_next = shots_reg;
        if (in_flags.link) begin
            if (in_flags.speed_chg) begin
                if (shots_reg != SHOTS_MIN) begin
                    shots_next = shots_reg - 16'sd1;
                end
            end else if (in_flags.heat_chg) begin
                shots_next = in_flags.diff_q;
            end
        end else begin
            // clamped margin is non-negative, so its integer part is plain
            shots_next = $signed(div10_u16(in_margin[HEAT_FRAC_BITS +: 16]));
        end
        fire_next = (shots_next > 16'sd1) && in_flags.wheels_ok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
            shots_reg   <= '0;
        end else begin
            if (in_ready) begin
                o_valid_reg <= in_valid;
            end
            if (in_adv) begin
                shots_reg <= shots_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv) begin
            o_fire_reg    <= fire_next;
            o_allowed_reg <= shots_next;
            o_margin_reg  <= in_margin;
        end
    end

    `HBFL_ASSERT_NEXT(a_shot_decrement, aclk, aresetn,
        in_adv && in_flags.link && in_flags.speed_chg && (shots_reg != SHOTS_MIN),
        shots_reg == $past(shots_reg) - 16'sd1,
        "speed change did not take one shot off the count")

    `HBFL_ASSERT_NEXT(a_estimate_count_nonneg, aclk, aresetn,
        in_adv && !in_flags.link, !shots_reg[ALLOW_W-1],
        "local estimate produced a negative shot count")

endmodule

`default_nettype wire

// ----- rtl/heat_budget_fire_limiter_core.sv -----
// top level of the heat budget fire limiter: config registers, stage chain, stream ports
// path: each input transaction passes the a, b, c, d and result registers in order, held wherever ready drops
// throughput: one transaction per cycle unless m_tready stalls it, five register stages each with its own ready
// state that feeds back (last readings, margin, shot count) is read and written in one stage
// reset: aresetn synchronous active low, clears valids, tracking state, limit 240, cooling 40
`default_nettype none

module heat_budget_fire_limiter_core #(
    parameter int HEAT_FRAC_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // link_ok, heat_reading, speed_code, shot_total, time_ms,
    // left_wheel_alive, right_wheel_alive, zero pad
    input  logic [hbfl_pkg::IN_DATA_W-1:0]    s_tdata,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // fire_allowed, allowed_shots, heat_margin_q8, zero pad
    output logic [hbfl_pkg::OUT_DATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hbfl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hbfl_pkg::HEAT_W-1:0]       cfg_data
);
    import hbfl_pkg::*;

    localparam int MW = HEAT_FRAC_BITS + 18;
    localparam int XW = (MW > MARGIN_OUT_W) ? MW : MARGIN_OUT_W;

    logic [HEAT_W-1:0]    heat_limit_reg;
    logic [COOL_W-1:0]    cooling_rate_reg;

    item_t                in_item;
    logic                 fr_valid;
    logic                 fr_ready;
    front_t               fr_front;
    logic                 mg_valid;
    logic                 mg_ready;
    flags_t               mg_flags;
    logic signed [MW-1:0] mg_margin;
    logic                 res_fire;
    shots_t               res_allowed;
    logic signed [MW-1:0] res_margin;
    logic signed [XW-1:0] res_margin_ext;

    // register file is always ready, each accepted write is registered directly
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heat_limit_reg   <= HEAT_LIMIT_RESET;
            cooling_rate_reg <= COOLING_RATE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_HEAT_LIMIT: begin
                    heat_limit_reg <= cfg_data;
                end
                CFG_COOLING_RATE: begin
                    cooling_rate_reg <= cfg_data[COOL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // unpack the input transaction, first field in the low bits
    assign in_item.link        = s_tdata[0];
    assign in_item.heat        = s_tdata[16:1];
    assign in_item.speed       = s_tdata[32:17];
    assign in_item.shots       = s_tdata[48:33];
    assign in_item.time_ms     = s_tdata[80:49];
    assign in_item.left_alive  = s_tdata[81];
    assign in_item.right_alive = s_tdata[82];

    // input register, change detection, elapsed time and cooling product
    hbfl_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_item      (in_item),
        .heat_limit   (heat_limit_reg),
        .cooling_rate (cooling_rate_reg),
        .out_valid    (fr_valid),
        .out_ready    (fr_ready),
        .out_front    (fr_front)
    );

    // recovery quotient then margin update with clamp
    hbfl_margin #(
        .HEAT_FRAC_BITS (HEAT_FRAC_BITS)
    ) u_margin (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (fr_valid),
        .in_ready   (fr_ready),
        .in_front   (fr_front),
        .heat_limit (heat_limit_reg),
        .out_valid  (mg_valid),
        .out_ready  (mg_ready),
        .out_flags  (mg_flags),
        .out_margin (mg_margin)
    );

    // shot count, fire decision, result register
    hbfl_shots #(
        .HEAT_FRAC_BITS (HEAT_FRAC_BITS)
    ) u_shots (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (mg_valid),
        .in_ready    (mg_ready),
        .in_flags    (mg_flags),
        .in_margin   (mg_margin),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_fire    (res_fire),
        .out_allowed (res_allowed),
        .out_margin  (res_margin)
    );

    // margin goes out as 25 bits two's complement
    assign res_margin_ext = XW'(res_margin);

    assign m_tdata = {{(OUT_DATA_W-1-ALLOW_W-MARGIN_OUT_W){1'b0}},
                      res_margin_ext[MARGIN_OUT_W-1:0],
                      res_allowed,
                      res_fire};

endmodule

`default_nettype wire

// ----- tb/heat_budget_fire_limiter_checker.sv -----
// scoreboard for the heat budget fire limiter: tracks the heat budget and checks each result
`timescale 1ns / 100ps

module heat_budget_fire_limiter_checker #(
    parameter int HEAT_FRAC_BITS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [hbfl_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [hbfl_pkg::OUT_DATA_W-1:0]   m_tdata,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [hbfl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hbfl_pkg::HEAT_W-1:0]       cfg_data,
    output int                                fail_count,
    output int                                pending,
    output int                                checked
);
    import hbfl_pkg::*;

    typedef struct packed {
        logic               fire;
        logic signed [15:0] shots;
        logic [24:0]        margin;
    } budget_t;

    logic [HEAT_W-1:0]  heat_limit_r;
    logic [COOL_W-1:0]  cool_rate_r;
    longint             margin_q;      // heat margin, HEAT_FRAC_BITS fraction bits
    int                 shots_left;
    logic [HEAT_W-1:0]  prev_heat;
    logic [SPEED_W-1:0] prev_speed;
    logic [SHOT_W-1:0]  prev_shots;
    logic [TIME_W-1:0]  prev_time;
    budget_t            budget_q[$];
    int                 mismatches;
    int                 compared;

    function automatic item_t unpack_update(input logic [IN_DATA_W-1:0] d);
        item_t u;
        u.link        = d[0];
        u.heat        = d[16:1];
        u.speed       = d[32:17];
        u.shots       = d[48:33];
        u.time_ms     = d[80:49];
        u.left_alive  = d[81];
        u.right_alive = d[82];
        return u;
    endfunction

    function automatic budget_t unpack_budget(input logic [OUT_DATA_W-1:0] d);
        return '{fire: d[0], shots: d[16:1], margin: d[41:17]};
    endfunction

    // advances the tracked budget by one update and returns the result it produces
    function automatic budget_t predict_budget(input item_t u);
        longint      q_one;
        longint      diff;
        longint      cap;
        longint      gain;
        logic [63:0] recovered;
        logic [15:0] fired;
        logic [31:0] dt;
        budget_t     r;
        q_one = longint'(1) << HEAT_FRAC_BITS;
        diff  = longint'(heat_limit_r) - longint'(u.heat);
        if (u.link) begin
            // referee data is trusted: speed change means one shot, heat change or zero heat reloads
            if (u.speed != prev_speed) begin
                if (shots_left > -32768)
                    shots_left = shots_left - 1;
            end else if (u.heat != prev_heat || u.heat == 16'd0) begin
                shots_left = int'(diff / 10);
            end
            prev_heat  = u.heat;
            prev_speed = u.speed;
            margin_q   = diff * q_one;
        end else begin
            // local estimate: charge per shot, recover over elapsed time, clamp
            fired     = u.shots - prev_shots;
            dt        = u.time_ms - prev_time;
            cap       = longint'(heat_limit_r) * q_one;
            margin_q  = margin_q - longint'(fired) * 10 * q_one;
            recovered = {52'd0, cool_rate_r} * {32'd0, dt} * 64'(q_one);
            gain      = longint'(recovered / 64'd1000);
            margin_q  = margin_q + gain;
            prev_time = u.time_ms;
            if (margin_q > cap)
                margin_q = cap;
            if (margin_q < 0)
                margin_q = 0;
            shots_left = int'(margin_q / (10 * q_one));
            prev_shots = u.shots;
        end
        r.fire   = (shots_left > 1) && u.left_alive && u.right_alive;
        r.shots  = shots_left[15:0];
        r.margin = margin_q[24:0];
        return r;
    endfunction

    function automatic void flag_error(input string msg);
        mismatches = mismatches + 1;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    always @(posedge aclk) begin
        budget_t want;
        budget_t got;
        if (!aresetn) begin
            heat_limit_r = HEAT_LIMIT_RESET;
            cool_rate_r  = COOLING_RATE_RESET;
            margin_q     = 0;
            shots_left   = 0;
            prev_heat    = '0;
            prev_speed   = '0;
            prev_shots   = '0;
            prev_time    = '0;
            budget_q.delete();
            mismatches   = 0;
            compared     = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_HEAT_LIMIT:   heat_limit_r = cfg_data;
                    CFG_COOLING_RATE: cool_rate_r = cfg_data[COOL_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                budget_q.push_back(predict_budget(unpack_update(s_tdata)));
            if (m_tvalid && m_tready) begin
                got = unpack_budget(m_tdata);
                compared = compared + 1;
                if (budget_q.size() == 0) begin
                    flag_error($sformatf("%0t: result with no update waiting: fire %0b shots %0d margin %0d",
                        $time, got.fire, got.shots, $signed(got.margin)));
                end else begin
                    want = budget_q.pop_front();
                    if (got.fire !== want.fire || got.shots !== want.shots
                            || got.margin !== want.margin)
                        flag_error($sformatf({"%0t: mismatch, expected fire %0b shots %0d margin %0d,",
                            " got fire %0b shots %0d margin %0d"}, $time,
                            want.fire, want.shots, $signed(want.margin),
                            got.fire, got.shots, $signed(got.margin)));
                end
            end
        end
        fail_count <= mismatches;
        pending    <= budget_q.size();
        checked    <= compared;
    end

endmodule

// ----- tb/heat_budget_fire_limiter_core_tb.sv -----
// testbench top for the heat budget fire limiter: stimulus, handshake pacing and verdict
`timescale 1ns / 100ps

module heat_budget_fire_limiter_core_tb;
    import hbfl_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;   // quiet cycles allowed before giving up
    localparam int DRAIN_CYCLES   = 16;     // well past the result latency
    localparam int SAT_STEPS      = 100;    // back-to-back speed changes after the deepest reload
    localparam int PHASES         = 6;
    localparam int PHASE_ITEMS    = 180;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [HEAT_W-1:0]      cfg_data;

    int fail_count;
    int pending;
    int checked;

    int sent        = 0;
    int idle_cycles = 0;
    bit calm        = 1'b0;   // when set, neither side inserts gaps

    // running sequence state for well-formed updates
    logic                cur_link  = 1'b1;
    logic [HEAT_W-1:0]   cur_heat  = '0;
    logic [SPEED_W-1:0]  cur_speed = '0;
    logic [SHOT_W-1:0]   cur_shots = '0;
    logic [TIME_W-1:0]   cur_time  = '0;
    logic [HEAT_W-1:0]   lim       = HEAT_LIMIT_RESET;

    heat_budget_fire_limiter_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    heat_budget_fire_limiter_checker i_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // tdata layout from bit 0: link, heat, speed, shot total, time, left wheel, right wheel
    function automatic logic [IN_DATA_W-1:0] pack_update(input item_t u);
        return {5'd0, u.right_alive, u.left_alive, u.time_ms, u.shots, u.speed, u.heat, u.link};
    endfunction

    function automatic item_t upd(input logic link, input logic [15:0] heat,
                                  input logic [15:0] speed, input logic [15:0] shots,
                                  input logic [31:0] tms, input logic left, input logic right);
        item_t u;
        u.link        = link;
        u.heat        = heat;
        u.speed       = speed;
        u.shots       = shots;
        u.time_ms     = tms;
        u.left_alive  = left;
        u.right_alive = right;
        return u;
    endfunction

    // mostly coherent update sequences, with some updates drawn over the full field range
    function automatic item_t next_update();
        item_t u;
        if ($urandom_range(0, 99) < 12) begin
            u.link        = 1'($urandom);
            u.heat        = 16'($urandom);
            u.speed       = 16'($urandom);
            u.shots       = 16'($urandom);
            u.time_ms     = $urandom;
            u.left_alive  = 1'($urandom);
            u.right_alive = 1'($urandom);
            return u;
        end
        // link drops and recovers in runs
        if ($urandom_range(0, 9) == 0)
            cur_link = ~cur_link;
        case ($urandom_range(0, 9))
            0:       cur_heat = 16'd0;
            1:       cur_heat = 16'($urandom);
            2, 3, 4: cur_heat = 16'($urandom_range(0, int'(lim) + 20));
            default: ;
        endcase
        // a new speed code stands for a shot seen by the referee
        if ($urandom_range(0, 3) == 0)
            cur_speed = 16'($urandom);
        cur_shots = cur_shots + 16'($urandom_range(0, 3));
        if ($urandom_range(0, 30) == 0)
            cur_time = cur_time + $urandom;
        else
            cur_time = cur_time + $urandom_range(0, 1500);
        u.link        = cur_link;
        u.heat        = cur_heat;
        u.speed       = cur_speed;
        u.shots       = cur_shots;
        u.time_ms     = cur_time;
        u.left_alive  = ($urandom_range(0, 9) != 0);
        u.right_alive = ($urandom_range(0, 9) != 0);
        return u;
    endfunction

    // one input transaction, preceded by a random gap unless calm
    task automatic send_update(input item_t u);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = pack_update(u);
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent = sent + 1;
    endtask

    // stop sending, wait for every expected result, then let the pipeline go quiet
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HEAT_W-1:0] val);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // result side: a random stall before each result transaction
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 5);
            @(negedge aclk);
            if (stall != 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // watchdog: any transaction on any channel counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("heat_budget_fire_limiter_core verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int                ph;
        int                n;
        logic [HEAT_W-1:0] rate;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_HEAT_LIMIT;
        cfg_data  = '0;
        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // directed part at the reset settings: limit 240, cooling 40
        send_update(upd(1'b1, 16'd0,    16'd0, 16'd0, 32'd0, 1'b1, 1'b1));   // zero heat reloads
        send_update(upd(1'b1, 16'd100,  16'd0, 16'd0, 32'd0, 1'b1, 1'b1));   // heat change reloads
        send_update(upd(1'b1, 16'd100,  16'd7, 16'd0, 32'd0, 1'b1, 1'b1));   // speed change, one shot
        send_update(upd(1'b1, 16'd100,  16'd7, 16'd0, 32'd0, 1'b1, 1'b0));   // no change, right wheel out
        send_update(upd(1'b1, 16'd100,  16'd7, 16'd0, 32'd0, 1'b0, 1'b1));   // left wheel out
        send_update(upd(1'b1, 16'd230,  16'd7, 16'd0, 32'd0, 1'b1, 1'b1));   // one shot left, no fire
        send_update(upd(1'b1, 16'd220,  16'd7, 16'd0, 32'd0, 1'b1, 1'b1));   // two left, fire
        send_update(upd(1'b1, 16'd300,  16'd7, 16'd0, 32'd0, 1'b1, 1'b1));   // over the limit
        send_update(upd(1'b1, 16'hFFFF, 16'd7, 16'd0, 32'd0, 1'b1, 1'b1));   // deepest negative reload
        send_update(upd(1'b1, 16'hFFFF, 16'hFFFF, 16'd0, 32'd0, 1'b1, 1'b1));
        // link down: first estimate sees a huge elapsed time and clamps to the limit
        send_update(upd(1'b0, 16'd0, 16'd0, 16'd5, 32'hFFFF_FFF0, 1'b1, 1'b1));
        send_update(upd(1'b0, 16'd0, 16'd0, 16'd5, 32'hFFFF_FFF0, 1'b1, 1'b1));   // nothing elapsed
        send_update(upd(1'b0, 16'd0, 16'd0, 16'd8, 32'hFFFF_FFF0, 1'b1, 1'b1));   // three shots
        send_update(upd(1'b0, 16'd0, 16'd0, 16'hFFFE, 32'hFFFF_FFF0, 1'b1, 1'b1)); // huge count, floor
        send_update(upd(1'b0, 16'd0, 16'd0, 16'hFFFE, 32'h000F_4230, 1'b1, 1'b1)); // time wraps
        send_update(upd(1'b0, 16'd0, 16'd0, 16'h0001, 32'h000F_4230, 1'b1, 1'b1)); // count wraps
        send_update(upd(1'b0, 16'd0, 16'd0, 16'h0001, 32'h000F_4231, 1'b1, 1'b1)); // fractional gain
        send_update(upd(1'b0, 16'd0, 16'd0, 16'h0001, 32'h000F_4256, 1'b1, 1'b1));
        send_update(upd(1'b0, 16'd0, 16'd0, 16'h0002, 32'h000F_426F, 1'b0, 1'b0));
        send_update(upd(1'b1, 16'd240, 16'hFFFF, 16'd0, 32'd0, 1'b1, 1'b1));   // link back, no budget
        send_update(upd(1'b1, 16'd240, 16'hFFFF, 16'd0, 32'd0, 1'b1, 1'b1));
        send_update(upd(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
        settle();

        // zero limit and zero cooling: deepest negative reload, then a run of speed changes
        write_reg(CFG_HEAT_LIMIT, 16'd0);
        write_reg(CFG_COOLING_RATE, 16'd0);
        calm = 1'b1;
        send_update(upd(1'b1, 16'hFFFE, 16'hFFFF, 16'd0, 32'd0, 1'b1, 1'b1));
        for (n = 0; n < SAT_STEPS; n++)
            send_update(upd(1'b1, 16'hFFFE, 16'(n & 1), 16'd0, 32'd0, 1'b1, 1'b1));
        send_update(upd(1'b0, 16'd0, 16'd0, 16'd3, 32'd500, 1'b1, 1'b1));   // clamps to a zero cap
        calm = 1'b0;
        settle();

        // random phases, each under its own register setting
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin lim = 16'hFFFF; rate = 16'd4095; end
                1: begin lim = HEAT_LIMIT_RESET; rate = 16'(COOLING_RATE_RESET); end
                2: begin lim = 16'($urandom_range(0, 400)); rate = 16'($urandom_range(0, 100)); end
                3: begin lim = 16'hFFFF; rate = 16'd0; end
                4: begin lim = 16'd0; rate = 16'd4095; end
                default: begin lim = 16'($urandom); rate = 16'($urandom_range(0, 4095)); end
            endcase
            write_reg(CFG_HEAT_LIMIT, lim);
            write_reg(CFG_COOLING_RATE, rate);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // stretches with no gaps at all, now and then
                if (n % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                send_update(next_update());
            end
            calm = 1'b0;
            settle();
        end

        $display("covered %0d updates, %0d results compared, incl. a %0d-step speed change run",
                 sent, checked, SAT_STEPS);
        $display("register settings: %0d random phases, limit and cooling at both extremes",
                 PHASES);
        if (fail_count == 0 && pending == 0)
            $display("heat_budget_fire_limiter_core verification clean");
        else
            $display("heat_budget_fire_limiter_core verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/hbfl_pkg.sv
rtl/hbfl_front.sv
rtl/hbfl_margin.sv
rtl/hbfl_shots.sv
rtl/heat_budget_fire_limiter_core.sv
tb/heat_budget_fire_limiter_checker.sv
tb/heat_budget_fire_limiter_core_tb.sv
